// ===== rtl/asdq_pkg.sv =====
// Constants, stage types and step functions of the animation sample dequantizer.
`default_nettype none

package asdq_pkg;

    localparam int CODE_W   = 16;
    localparam int POS_W    = 32;
    localparam int QUAT_W   = 16;
    localparam int QMAG_W   = 15;
    localparam int QW_W     = 15;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_POS_SCALE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_OFFSET = 1'd1;

    localparam logic [15:0] ROT_MIDDLE = 16'd32767;
    localparam logic [31:0] ROT_BIAS   = 32'd109225;
    localparam logic [31:0] ROT_DEN    = 32'd218450;
    localparam logic [22:0] ROT_RECIP  = 23'd5033241;
    localparam logic [31:0] ONE_Q28    = 32'd268435456;

    localparam int SQ_OPND_W = 60;
    localparam int SQ_ROOT_W = 30;
    localparam int SQ_REM_W  = 34;
    localparam int SQ_PER    = 3;
    localparam int SQ_STAGES = SQ_ROOT_W / SQ_PER;

    localparam int DV_W      = 44;
    localparam int DV_PER    = 3;
    localparam int DV_STAGES = QMAG_W / DV_PER;

    typedef struct packed {
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_ROOT_W-1:0] root;
        logic [SQ_OPND_W-1:0] opnd;
    } sq_t;

    typedef struct packed {
        logic [DV_W-1:0]   rem;
        logic [DV_W-1:0]   dsh;
        logic [QMAG_W-1:0] quo;
    } dv_t;

    typedef struct packed {
        logic [2:0][POS_W-1:0]  pos;
        logic [2:0]             neg;
        logic [2:0][QMAG_W-1:0] mag;
        logic                   norm;
    } car_t;

    function automatic sq_t sq_stage(input sq_t a);
        sq_t                  s;
        logic [SQ_REM_W-1:0]  rem2;
        logic [SQ_REM_W-1:0]  t;
        s = a;
        for (int k = 0; k < SQ_PER; k++)
        begin
            rem2 = {s.rem[SQ_REM_W-3:0], s.opnd[SQ_OPND_W-1 -: 2]};
            t    = SQ_REM_W'({s.root, 2'b01});
            if (rem2 >= t)
            begin
                s.rem  = rem2 - t;
                s.root = {s.root[SQ_ROOT_W-2:0], 1'b1};
            end
            else
            begin
                s.rem  = rem2;
                s.root = {s.root[SQ_ROOT_W-2:0], 1'b0};
            end
            s.opnd = {s.opnd[SQ_OPND_W-3:0], 2'b00};
        end
        return s;
    endfunction

    function automatic dv_t dv_stage(input dv_t a);
        dv_t s;
        s = a;
        for (int k = 0; k < DV_PER; k++)
        begin
            if (s.rem >= s.dsh)
            begin
                s.rem = s.rem - s.dsh;
                s.quo = {s.quo[QMAG_W-2:0], 1'b1};
            end
            else
            begin
                s.quo = {s.quo[QMAG_W-2:0], 1'b0};
            end
            s.dsh = {1'b0, s.dsh[DV_W-1:1]};
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/anim_sample_dequantize.sv =====
// Top level of the animation sample dequantizer: position scaling and quaternion rebuild.
//
// Usage: drive the six raw codes with start high for one cycle per sample.
// busy is always low, so a transaction is taken at every rising edge with
// start high; a new sample may follow in every cycle.
// pos_scale and pos_offset are written through cfg_we, cfg_index, cfg_data. The user
// must write them only while no sample is in flight; the block does not enforce this.
// Unknown indexes are dropped. Each result is marked by done for exactly one cycle.
// Throughput is one sample per cycle. The pipeline is made of the restoring
// square root (ten stages of three digits) and the three restoring dividers
// (a load stage and five stages of three quotient bits) that rescale an
// over-long vector part, plus six stages of position and rotation scaling
// and the output register.
// Results leave in the order samples entered. The receiver cannot stall:
// done and the result fields are valid for that one cycle only.
// Reset clears both configuration registers and every in-flight valid bit;
// samples in flight at reset are dropped.
`default_nettype none

module anim_sample_dequantize
    import asdq_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [31:0]             cfg_data,
    input  wire logic                    start,
    output      logic                    busy,
    input  wire logic [CODE_W-1:0]       raw_pos_x,
    input  wire logic [CODE_W-1:0]       raw_pos_y,
    input  wire logic [CODE_W-1:0]       raw_pos_z,
    input  wire logic [CODE_W-1:0]       raw_rot_x,
    input  wire logic [CODE_W-1:0]       raw_rot_y,
    input  wire logic [CODE_W-1:0]       raw_rot_z,
    output      logic                    done,
    output      logic signed [POS_W-1:0] pos_x,
    output      logic signed [POS_W-1:0] pos_y,
    output      logic signed [POS_W-1:0] pos_z,
    output      logic signed [QUAT_W-1:0] quat_x,
    output      logic signed [QUAT_W-1:0] quat_y,
    output      logic signed [QUAT_W-1:0] quat_z,
    output      logic [QW_W-1:0]         quat_w,
    output      logic                    was_normalized
);

    localparam int LAT = 6 + SQ_STAGES + 1 + DV_STAGES + 1;

    logic [31:0]     pos_scale_reg;
    logic [31:0]     pos_offset_reg;
    logic [LAT-1:0]  vld_reg;

    logic [2:0][CODE_W-1:0] pc;
    logic [2:0][CODE_W-1:0] rc;

    // stage 1
    logic [2:0][47:0] s1_pprod_reg, s1_pprod_next;
    logic [2:0][31:0] s1_n_reg, s1_n_next;
    logic [2:0]       s1_neg_reg, s1_neg_next;
    // stage 2
    logic [2:0][POS_W-1:0] s2_pos_reg, s2_pos_next;
    logic [2:0][54:0]      s2_rprod_reg, s2_rprod_next;
    logic [2:0][31:0]      s2_n_reg;
    logic [2:0]            s2_neg_reg;
    // stage 3
    logic [2:0][POS_W-1:0]  s3_pos_reg;
    logic [2:0][QMAG_W-1:0] s3_q0_reg, s3_q0_next;
    logic [2:0][31:0]       s3_qd_reg, s3_qd_next;
    logic [2:0][31:0]       s3_n_reg;
    logic [2:0]             s3_neg_reg;
    // stage 4, 5
    car_t                   s4_reg, s4_next;
    car_t                   s5_reg;
    logic [2:0][29:0]       s5_sq_reg, s5_sq_next;
    // square root and dividers
    car_t                   sq_car_reg [SQ_STAGES+1];
    sq_t                    sq_reg [SQ_STAGES+1];
    sq_t                    sq_next [SQ_STAGES+1];
    logic [31:0]            len;
    car_t                   s6_car_next;
    car_t                   dv_car_reg [DV_STAGES+1];
    logic [QW_W-1:0]        dv_w_reg [DV_STAGES+1];
    logic [QW_W-1:0]        w_next;
    dv_t                    dv_reg [DV_STAGES+1][3];
    dv_t                    dv_next [DV_STAGES+1][3];
    logic [SQ_ROOT_W-1:0]   s_root;

    logic [2:0][QUAT_W-1:0] quat_next;

    assign busy = 1'b0;
    assign pc = {raw_pos_z, raw_pos_y, raw_pos_x};
    assign rc = {raw_rot_z, raw_rot_y, raw_rot_x};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_scale_reg  <= '0;
            pos_offset_reg <= '0;
            vld_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_POS_SCALE:  pos_scale_reg  <= cfg_data;
                    REG_POS_OFFSET: pos_offset_reg <= cfg_data;
                    default:        ;
                endcase
            end
            vld_reg <= {vld_reg[LAT-2:0], start};
        end
    end

    always_comb
    begin
        logic [15:0] m;
        for (int i = 0; i < 3; i++)
        begin
            s1_pprod_next[i] = 48'(pc[i]) * 48'(pos_scale_reg);
            s1_neg_next[i]   = rc[i] < ROT_MIDDLE;
            m = s1_neg_next[i] ? ROT_MIDDLE - rc[i] : rc[i] - ROT_MIDDLE;
            s1_n_next[i] = (32'(m) << 16) + (32'(m) << 15) + (32'(m) << 14) + ROT_BIAS;
        end
    end

    always_comb
    begin
        logic [40:0]        pq;
        logic signed [42:0] sum;
        for (int i = 0; i < 3; i++)
        begin
            pq  = 41'((49'(s1_pprod_reg[i]) + 49'd128) >> 8);
            sum = $signed({2'b00, pq}) + 43'(signed'(pos_offset_reg));
            if (sum > 43'sd2147483647)
                s2_pos_next[i] = 32'h7FFF_FFFF;
            else if (sum < -43'sd2147483648)
                s2_pos_next[i] = 32'h8000_0000;
            else
                s2_pos_next[i] = sum[31:0];
            s2_rprod_next[i] = 55'(s1_n_reg[i]) * 55'(ROT_RECIP);
            s3_q0_next[i] = s2_rprod_reg[i][54:40];
            s3_qd_next[i] = 32'(s3_q0_next[i]) * ROT_DEN;
        end
    end

    always_comb
    begin
        logic [31:0] r;
        s4_next.pos  = s3_pos_reg;
        s4_next.neg  = s3_neg_reg;
        s4_next.norm = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            r = s3_n_reg[i] - s3_qd_reg[i];
            s4_next.mag[i] = s3_q0_reg[i] + QMAG_W'(r >= ROT_DEN);
            s5_sq_next[i]  = 30'(s4_reg.mag[i]) * 30'(s4_reg.mag[i]);
        end
    end

    always_comb
    begin
        len = 32'(s5_sq_reg[0]) + 32'(s5_sq_reg[1]) + 32'(s5_sq_reg[2]);
        s6_car_next      = s5_reg;
        s6_car_next.norm = len > ONE_Q28;
        sq_next[0].rem   = '0;
        sq_next[0].root  = '0;
        sq_next[0].opnd  = s6_car_next.norm ? SQ_OPND_W'({len[29:0], 28'b0})
                                            : SQ_OPND_W'(ONE_Q28 - len);
        for (int k = 1; k <= SQ_STAGES; k++)
            sq_next[k] = sq_stage(sq_reg[k-1]);
    end

    always_comb
    begin
        s_root = sq_reg[SQ_STAGES].root;
        w_next = QW_W'(s_root) + QW_W'(sq_reg[SQ_STAGES].rem > SQ_REM_W'(s_root));
        for (int i = 0; i < 3; i++)
        begin
            dv_next[0][i].rem = DV_W'({sq_car_reg[SQ_STAGES].mag[i], 28'b0})
                                + DV_W'(s_root >> 1);
            dv_next[0][i].dsh = DV_W'({s_root, 14'b0});
            dv_next[0][i].quo = '0;
            for (int k = 1; k <= DV_STAGES; k++)
                dv_next[k][i] = dv_stage(dv_reg[k-1][i]);
        end
    end

    always_comb
    begin
        logic [QMAG_W-1:0] mg;
        for (int i = 0; i < 3; i++)
        begin
            mg = dv_car_reg[DV_STAGES].norm ? dv_reg[DV_STAGES][i].quo
                                            : dv_car_reg[DV_STAGES].mag[i];
            quat_next[i] = dv_car_reg[DV_STAGES].neg[i] ? QUAT_W'(0) - QUAT_W'(mg)
                                                        : QUAT_W'(mg);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pprod_reg <= s1_pprod_next;
        s1_n_reg     <= s1_n_next;
        s1_neg_reg   <= s1_neg_next;
        s2_pos_reg   <= s2_pos_next;
        s2_rprod_reg <= s2_rprod_next;
        s2_n_reg     <= s1_n_reg;
        s2_neg_reg   <= s1_neg_reg;
        s3_pos_reg   <= s2_pos_reg;
        s3_q0_reg    <= s3_q0_next;
        s3_qd_reg    <= s3_qd_next;
        s3_n_reg     <= s2_n_reg;
        s3_neg_reg   <= s2_neg_reg;
        s4_reg       <= s4_next;
        s5_reg       <= s4_reg;
        s5_sq_reg    <= s5_sq_next;
        sq_car_reg[0] <= s6_car_next;
        sq_reg[0]     <= sq_next[0];
        for (int k = 1; k <= SQ_STAGES; k++)
        begin
            sq_car_reg[k] <= sq_car_reg[k-1];
            sq_reg[k]     <= sq_next[k];
        end
        dv_car_reg[0] <= sq_car_reg[SQ_STAGES];
        dv_w_reg[0]   <= w_next;
        for (int i = 0; i < 3; i++)
            dv_reg[0][i] <= dv_next[0][i];
        for (int k = 1; k <= DV_STAGES; k++)
        begin
            dv_car_reg[k] <= dv_car_reg[k-1];
            dv_w_reg[k]   <= dv_w_reg[k-1];
            for (int i = 0; i < 3; i++)
                dv_reg[k][i] <= dv_next[k][i];
        end
        pos_x          <= dv_car_reg[DV_STAGES].pos[0];
        pos_y          <= dv_car_reg[DV_STAGES].pos[1];
        pos_z          <= dv_car_reg[DV_STAGES].pos[2];
        quat_x         <= quat_next[0];
        quat_y         <= quat_next[1];
        quat_z         <= quat_next[2];
        quat_w         <= dv_car_reg[DV_STAGES].norm ? '0 : dv_w_reg[DV_STAGES];
        was_normalized <= dv_car_reg[DV_STAGES].norm;
    end

    assign done = vld_reg[LAT-1];

endmodule

`default_nettype wire
